// ===== hdl/sml_pkg.sv =====
// Shared types and constants for the sorted map on a linked slot store.
// No dependencies; imported by the controller, the datapath and the top level.
package sml_pkg;

	// Default sizes of the slot store and of the key and value words.
	localparam int CAPACITY_DEF    = 64;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	// Operation codes carried by a request.
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start_load;   // capture request, point at list head
		logic walk_adv;     // step to the next node of the pair chain
		logic rd_free;      // read the link of the free-chain head
		logic replace;      // overwrite the value of the current node
		logic unlink;       // bypass the current node in the pair chain
		logic alloc;        // fill the free-chain head slot with the new pair
		logic link_prev;    // point the previous node at the new slot
		logic free_slot;    // push the current node onto the free chain
		logic set_found;    // record a hit and its value
		logic set_full;     // record a refused add
		logic load_result;  // move the outcome to the result registers
	} sml_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cur_nil;   // current node is the end of the chain
		logic prev_nil;  // no previous node, current is the head
		logic free_nil;  // no free slot left
		logic key_eq;    // stored key equals the request key
		logic rel_ok;    // stored key is in order before or at the request key
	} sml_stat_t;

endpackage

// ===== hdl/sml_ctrl.sv =====
// Controller state machine for the sorted map: sequences walks and relinks.
// Depends on sml_pkg for the command and status structs and the operation codes.
module sml_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       cmd,
	input  sml_pkg::sml_stat_t st,
	output sml_pkg::sml_cmd_t  c,
	output logic             busy,
	output logic             done
);
	import sml_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_WALK      = 7'b0000010,
		S_ADD_TRY   = 7'b0000100,
		S_ALLOC_WR  = 7'b0001000,
		S_LINK_PREV = 7'b0010000,
		S_FREE_SLOT = 7'b0100000,
		S_FINISH    = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cmd_q;
	logic       accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		c       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					c.start_load = 1'b1;
					if (cmd == CMD_ADD || cmd == CMD_SEARCH || cmd == CMD_REMOVE)
						state_d = S_WALK;
					else
						state_d = S_FINISH;
				end
			end
			S_WALK: begin
				if (st.cur_nil) begin
					state_d = (cmd_q == CMD_ADD) ? S_ADD_TRY : S_FINISH;
				end else begin
					case (cmd_q)
						CMD_ADD: begin
							if (st.key_eq) begin
								c.replace   = 1'b1;
								c.set_found = 1'b1;
								state_d     = S_FINISH;
							end else if (st.rel_ok) begin
								c.walk_adv = 1'b1;
							end else begin
								state_d = S_ADD_TRY;
							end
						end
						CMD_SEARCH: begin
							if (st.key_eq) begin
								c.set_found = 1'b1;
								state_d     = S_FINISH;
							end else if (!st.rel_ok) begin
								state_d = S_FINISH;
							end else begin
								c.walk_adv = 1'b1;
							end
						end
						default: begin
							// Remove walks on equality alone.
							if (st.key_eq) begin
								c.set_found = 1'b1;
								c.unlink    = 1'b1;
								state_d     = S_FREE_SLOT;
							end else begin
								c.walk_adv = 1'b1;
							end
						end
					endcase
				end
			end
			S_ADD_TRY: begin
				if (st.free_nil) begin
					c.set_full = 1'b1;
					state_d    = S_FINISH;
				end else begin
					c.rd_free = 1'b1;
					state_d   = S_ALLOC_WR;
				end
			end
			S_ALLOC_WR: begin
				c.alloc = 1'b1;
				state_d = st.prev_nil ? S_FINISH : S_LINK_PREV;
			end
			S_LINK_PREV: begin
				c.link_prev = 1'b1;
				state_d     = S_FINISH;
			end
			S_FREE_SLOT: begin
				c.free_slot = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				c.load_result = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, latched operation code and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_ADD;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == S_FINISH);
			if (accept)
				cmd_q <= cmd;
		end
	end

endmodule

// ===== hdl/sml_datapath.sv =====
// Datapath of the sorted map: slot memories, chain pointers, counters, results.
// Depends on sml_pkg for the command and status structs.
module sml_datapath #(
	parameter int CAPACITY    = sml_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH   = sml_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = sml_pkg::VALUE_WIDTH_DEF,
	localparam int PW         = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sml_pkg::sml_cmd_t             c,
	output sml_pkg::sml_stat_t            st,
	input  logic signed [KEY_WIDTH-1:0]   key,
	input  logic signed [VALUE_WIDTH-1:0] value_in,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	output logic signed [VALUE_WIDTH-1:0] value_out,
	output logic                          found,
	output logic                          status,
	output logic [PW-1:0]                 pair_count,
	output logic                          is_empty
);
	import sml_pkg::*;

	localparam int          AW  = $clog2(CAPACITY);
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	// Slot memories; they have no reset, and their contents matter only on chain slots.
	logic [KEY_WIDTH-1:0]   key_mem  [CAPACITY];
	logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
	logic [PW-1:0]          link_mem [CAPACITY];

	logic signed [KEY_WIDTH-1:0]   key_rd, key_q;
	logic signed [VALUE_WIDTH-1:0] val_rd, val_q, vout_q;
	logic [PW-1:0] link_rd;
	logic [PW-1:0] head_q, free_q, hw_q, count_q, cur_q, prev_q, np_q;
	logic          order_q, found_q, full_q;

	logic [PW-1:0] rd_addr, link_waddr, link_wdata, val_waddr, free_next;
	logic          link_we, val_we, fresh;

	// Status toward the controller.
	assign st.cur_nil  = (cur_q == NIL);
	assign st.prev_nil = (prev_q == NIL);
	assign st.free_nil = (free_q == NIL);
	assign st.key_eq   = (key_rd == key_q);
	assign st.rel_ok   = order_q ? (key_rd >= key_q) : (key_rd <= key_q);

	// Slots at or above the high-water mark were never linked: they chain upward.
	assign fresh     = (free_q >= hw_q);
	assign free_next = fresh ? (free_q + PW'(1)) : link_rd;

	// Read address: one slot per cycle, following the chain as it is read.
	always_comb begin
		if (c.start_load)
			rd_addr = head_q;
		else if (c.walk_adv)
			rd_addr = link_rd;
		else if (c.rd_free)
			rd_addr = free_q;
		else
			rd_addr = cur_q;
	end

	// Link write port.
	always_comb begin
		link_we    = 1'b1;
		link_waddr = cur_q;
		link_wdata = free_q;
		if (c.unlink) begin
			link_we    = !st.prev_nil;
			link_waddr = prev_q;
			link_wdata = link_rd;
		end else if (c.alloc) begin
			link_waddr = free_q;
			link_wdata = cur_q;
		end else if (c.link_prev) begin
			link_waddr = prev_q;
			link_wdata = np_q;
		end else if (!c.free_slot) begin
			link_we = 1'b0;
		end
	end

	// Value write port: new pair or replacement.
	assign val_we    = c.alloc || c.replace;
	assign val_waddr = c.alloc ? free_q : cur_q;

	// Memories with registered read data.
	always_ff @(posedge clk) begin
		if (c.alloc)
			key_mem[free_q[AW-1:0]] <= key_q;
		if (val_we)
			val_mem[val_waddr[AW-1:0]] <= val_q;
		if (link_we)
			link_mem[link_waddr[AW-1:0]] <= link_wdata;
		key_rd  <= key_mem[rd_addr[AW-1:0]];
		val_rd  <= val_mem[rd_addr[AW-1:0]];
		link_rd <= link_mem[rd_addr[AW-1:0]];
	end

	// Chain heads, high-water mark, pair count and ordering mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			free_q  <= '0;
			hw_q    <= '0;
			count_q <= '0;
			order_q <= 1'b0;
		end else begin
			if (cfg_we)
				order_q <= cfg_wdata;
			if (c.unlink && st.prev_nil)
				head_q <= link_rd;
			if (c.alloc) begin
				free_q  <= free_next;
				count_q <= count_q + PW'(1);
				if (fresh)
					hw_q <= free_q + PW'(1);
				if (st.prev_nil)
					head_q <= free_q;
			end
			if (c.free_slot) begin
				free_q <= cur_q;
				if (count_q != '0)
					count_q <= count_q - PW'(1);
			end
		end
	end

	// Request capture, walk pointers and outcome.
	always_ff @(posedge clk) begin
		if (c.start_load) begin
			key_q   <= key;
			val_q   <= value_in;
			cur_q   <= head_q;
			prev_q  <= NIL;
			found_q <= 1'b0;
			full_q  <= 1'b0;
			vout_q  <= '0;
		end
		if (c.walk_adv) begin
			prev_q <= cur_q;
			cur_q  <= link_rd;
		end
		if (c.alloc)
			np_q <= free_q;
		if (c.set_found) begin
			found_q <= 1'b1;
			vout_q  <= val_rd;
		end
		if (c.set_full)
			full_q <= 1'b1;
		if (c.load_result) begin
			value_out  <= vout_q;
			found      <= found_q;
			status     <= full_q;
			pair_count <= count_q;
			is_empty   <= (count_q == '0);
		end
	end

endmodule

// ===== hdl/sorted_map_linked_array_unit.sv =====
// Top level of the sorted map on a linked slot store.
// Depends on sml_pkg, sml_ctrl and sml_datapath.
//
// Usage: a request (cmd, key, value_in) is taken at a rising edge where start
// is high and busy is low. cmd selects add-or-replace, search or remove.
// Each request gives exactly one result on value_out, found, status,
// pair_count and is_empty, shown for one cycle while done is high. The
// receiver cannot stall; a result must be captured in its done cycle.
// cfg_we with cfg_wdata sets the key order (0 ascending, 1 descending). It is
// to be written only while the block is idle; the block does not enforce it.
// A search or a replace stops at a node; a remove that hits also frees that
// slot, and an add of a new key takes the free-chain head and links it in
// after the walk. The walk visits one list node per cycle, set by the single
// read port of the slot memories; a new request can be taken in the cycle
// that done is high, so one request is in flight at a time.
// Reset clears the chains: no pairs, all slots free, ascending order. There
// is no clearing pass; requests are taken from the first edge after reset.
module sorted_map_linked_array_unit #(
	parameter int CAPACITY    = sml_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH   = sml_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = sml_pkg::VALUE_WIDTH_DEF,
	localparam int PW         = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    cmd,
	input  logic signed [KEY_WIDTH-1:0]   key,
	input  logic signed [VALUE_WIDTH-1:0] value_in,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	output logic                          busy,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] value_out,
	output logic                          found,
	output logic                          status,
	output logic [PW-1:0]                 pair_count,
	output logic                          is_empty
);
	import sml_pkg::*;

	sml_cmd_t  dp_cmd;
	sml_stat_t dp_stat;

	// Controller.
	sml_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.st     (dp_stat),
		.c      (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath.
	sml_datapath #(
		.CAPACITY    (CAPACITY),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.c          (dp_cmd),
		.st         (dp_stat),
		.key        (key),
		.value_in   (value_in),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.value_out  (value_out),
		.found      (found),
		.status     (status),
		.pair_count (pair_count),
		.is_empty   (is_empty)
	);

endmodule

// ===== hdl/sml_checker.sv =====
// Port-level checks for the sorted map, attached to the top level by bind.
// Depends only on the top level's ports.
module sml_checker #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int PW         = $clog2(CAPACITY + 1)
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [VALUE_WIDTH-1:0] value_out,
	input logic                   found,
	input logic                   status,
	input logic [PW-1:0]          pair_count,
	input logic                   is_empty
);

	// An accepted request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request accepted but block not busy");

	// A result is shown only when the block is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// Results never come in consecutive cycles: each request gives one.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("repeated result strobe");

	// The empty flag agrees with the pair count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (pair_count == '0))) else $error("empty flag mismatch");

	// A refused add reports no hit and a zero value.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !found && (value_out == '0))
		else $error("refused add with hit or value");

endmodule

bind sorted_map_linked_array_unit sml_checker #(
	.CAPACITY    (CAPACITY),
	.VALUE_WIDTH (VALUE_WIDTH)
) u_sml_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.value_out  (value_out),
	.found      (found),
	.status     (status),
	.pair_count (pair_count),
	.is_empty   (is_empty)
);

// ===== verif/sorted_map_linked_array_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_map_linked_array_unit: a reference map
// kept in the testbench predicts every result of add, search and remove.
// Depends on sml_pkg and the RTL of the block.
module sorted_map_linked_array_unit_tb;
	import sml_pkg::*;

	localparam int SLOTS = CAPACITY_DEF;
	localparam logic [6:0] NIL = 7'(SLOTS);
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic ORDER_ASCENDING = 1'b0;
	localparam logic ORDER_DESCENDING = 1'b1;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
	localparam int PLANNED_REQUESTS = 550;
	localparam int QUIET_FROM = 480;

	typedef enum logic [1:0] {ENT_REQUEST, ENT_ORDER, ENT_SETTLE} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		logic [1:0] op;
		logic signed [31:0] k;
		logic signed [31:0] v;
		logic order;
		int unsigned gap;
	} plan_entry_t;

	typedef struct {
		logic [31:0] value;
		logic found;
		logic status;
		logic [6:0] count;
		logic empty;
	} map_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] cmd = CMD_ADD;
	logic signed [31:0] key = '0;
	logic signed [31:0] value_in = '0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = ORDER_ASCENDING;
	logic busy;
	logic done;
	logic signed [31:0] value_out;
	logic found;
	logic status;
	logic [6:0] pair_count;
	logic is_empty;

	plan_entry_t plan_q[$];
	map_result_t expected_results[$];
	int n_planned = 0;
	int n_req = 0;
	int n_res = 0;
	int error_count = 0;
	int unsigned gap_left = 0;

	// Reference copy of the slot store and its two chains.
	logic signed [31:0] map_keys [SLOTS];
	logic signed [31:0] map_vals [SLOTS];
	logic [6:0] map_next [SLOTS];
	logic [6:0] map_head;
	logic [6:0] map_free;
	logic [6:0] stored_pairs;
	logic map_descending;

	sorted_map_linked_array_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.key(key),
		.value_in(value_in),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.busy(busy),
		.done(done),
		.value_out(value_out),
		.found(found),
		.status(status),
		.pair_count(pair_count),
		.is_empty(is_empty)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	function automatic void map_reset();
		for (int i = 0; i < SLOTS; i++) begin
			map_keys[i] = '0;
			map_vals[i] = '0;
			map_next[i] = 7'(i + 1);
		end
		map_head = NIL;
		map_free = '0;
		stored_pairs = '0;
		map_descending = ORDER_ASCENDING;
	endfunction

	// True when stored key a may stand before key b under the current order.
	function automatic logic in_order(logic signed [31:0] a, logic signed [31:0] b);
		return map_descending ? (a >= b) : (a <= b);
	endfunction

	// Applies one request to the reference map and returns the result it gives.
	function automatic map_result_t apply_request(logic [1:0] op, logic signed [31:0] k,
			logic signed [31:0] v);
		map_result_t r;
		logic [6:0] cur;
		logic [6:0] prev;
		logic [6:0] slot;
		int steps;
		r.value = '0;
		r.found = 1'b0;
		r.status = 1'b0;
		cur = map_head;
		prev = NIL;
		steps = 0;
		case (op)
		CMD_ADD: begin
			// Walk while the order holds; an equal key is replaced in place.
			while (cur != NIL && steps < SLOTS && in_order(map_keys[cur], k)) begin
				if (map_keys[cur] == k) begin
					r.value = map_vals[cur];
					map_vals[cur] = v;
					r.found = 1'b1;
					break;
				end
				prev = cur;
				cur = map_next[cur];
				steps++;
			end
			if (!r.found) begin
				if (map_free == NIL) begin
					r.status = 1'b1;
				end else begin
					slot = map_free;
					map_free = map_next[slot];
					map_keys[slot] = k;
					map_vals[slot] = v;
					if (prev == NIL) begin
						map_next[slot] = map_head;
						map_head = slot;
					end else begin
						map_next[slot] = cur;
						map_next[prev] = slot;
					end
					stored_pairs++;
				end
			end
		end
		CMD_SEARCH: begin
			// The search gives up as soon as the order no longer holds.
			while (cur != NIL && steps < SLOTS) begin
				if (map_keys[cur] == k) begin
					r.value = map_vals[cur];
					r.found = 1'b1;
					break;
				end
				if (!in_order(map_keys[cur], k))
					break;
				cur = map_next[cur];
				steps++;
			end
		end
		CMD_REMOVE: begin
			// Remove scans the whole chain for the first equal key.
			while (cur != NIL && steps < SLOTS && map_keys[cur] != k) begin
				prev = cur;
				cur = map_next[cur];
				steps++;
			end
			if (cur != NIL && steps < SLOTS) begin
				r.value = map_vals[cur];
				r.found = 1'b1;
				if (prev == NIL)
					map_head = map_next[cur];
				else
					map_next[prev] = map_next[cur];
				map_next[cur] = map_free;
				map_free = cur;
				if (stored_pairs != 0)
					stored_pairs--;
			end
		end
		default: begin
		end
		endcase
		r.count = stored_pairs;
		r.empty = (stored_pairs == 0);
		return r;
	endfunction

	// Random idle burst before a request; none in calm phases or near the end.
	function automatic int unsigned pick_gap(bit calm);
		if (calm || n_planned >= QUIET_FROM)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
	endfunction

	function automatic void plan_request(logic [1:0] op, logic signed [31:0] k,
			logic signed [31:0] v, bit calm);
		plan_entry_t e;
		e.kind = ENT_REQUEST;
		e.op = op;
		e.k = k;
		e.v = v;
		e.order = ORDER_ASCENDING;
		e.gap = pick_gap(calm);
		plan_q.push_back(e);
		n_planned++;
	endfunction

	function automatic void plan_marker(entry_kind_t kind, logic order);
		plan_entry_t e;
		e.kind = kind;
		e.op = CMD_ADD;
		e.k = '0;
		e.v = '0;
		e.order = order;
		e.gap = 0;
		plan_q.push_back(e);
	endfunction

	function automatic void shuffle(ref int idx [96]);
		int j;
		int t;
		for (int i = 95; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = idx[i];
			idx[i] = idx[j];
			idx[j] = t;
		end
	endfunction

	// Request driver: holds each request until it is taken, inserts idle bursts,
	// and writes the order register only once every result has come back.
	always @(posedge clk or negedge arst_n) begin : request_driver
		logic take;
		logic settled;
		logic nx_start;
		logic nx_we;
		logic nx_order;
		logic [1:0] nx_cmd;
		logic signed [31:0] nx_key;
		logic signed [31:0] nx_val;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= CMD_ADD;
			key <= '0;
			value_in <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= ORDER_ASCENDING;
		end else begin
			take = start && !busy;
			settled = !start && (n_req == n_res);
			nx_start = start && !take;
			nx_cmd = cmd;
			nx_key = key;
			nx_val = value_in;
			nx_we = 1'b0;
			nx_order = cfg_wdata;
			if (take) begin
				expected_results.push_back(apply_request(cmd, key, value_in));
				n_req <= n_req + 1;
			end
			if (!nx_start) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (plan_q.size() != 0) begin
					case (plan_q[0].kind)
					ENT_REQUEST: begin
						if (plan_q[0].gap != 0) begin
							gap_left = plan_q[0].gap - 1;
							plan_q[0].gap = 0;
						end else begin
							nx_start = 1'b1;
							nx_cmd = plan_q[0].op;
							nx_key = plan_q[0].k;
							nx_val = plan_q[0].v;
							void'(plan_q.pop_front());
						end
					end
					ENT_ORDER: begin
						if (settled) begin
							nx_we = 1'b1;
							nx_order = plan_q[0].order;
							map_descending = plan_q[0].order;
							void'(plan_q.pop_front());
						end
					end
					default: begin
						if (settled)
							void'(plan_q.pop_front());
					end
					endcase
				end
			end
			start <= nx_start;
			cmd <= nx_cmd;
			key <= nx_key;
			value_in <= nx_val;
			cfg_we <= nx_we;
			cfg_wdata <= nx_order;
		end
	end

	// Result monitor: every strobed result is checked against the oldest prediction.
	always @(posedge clk) begin : result_monitor
		map_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("result with no request waiting", value_out, '0);
			end else begin
				want = expected_results.pop_front();
				if (value_out !== want.value)
					flag_mismatch("value_out", value_out, want.value);
				if (found !== want.found)
					flag_mismatch("found", 32'(found), 32'(want.found));
				if (status !== want.status)
					flag_mismatch("status", 32'(status), 32'(want.status));
				if (pair_count !== want.count)
					flag_mismatch("pair_count", 32'(pair_count), 32'(want.count));
				if (is_empty !== want.empty)
					flag_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
				n_res <= n_res + 1;
			end
		end
	end

	// Stimulus plan: a directed opening, then random phases under both orders.
	initial begin : stimulus_plan
		logic signed [31:0] pool [96];
		int idx [96];
		int phase_no;
		int sel;
		bit calm;
		logic [1:0] op;
		logic signed [31:0] k;
		map_reset();
		pool[0] = KEY_MIN;
		pool[1] = KEY_MAX;
		pool[2] = 32'sd0;
		pool[3] = -32'sd1;
		pool[4] = 32'sd1;
		for (int i = 5; i < 96; i++)
			pool[i] = $urandom;
		for (int i = 0; i < 96; i++)
			idx[i] = i;

		// Empty map, extreme keys and values, replace, head and middle removal.
		plan_marker(ENT_ORDER, ORDER_ASCENDING);
		plan_request(CMD_SEARCH, 32'sd0, 32'sd0, 0);
		plan_request(CMD_REMOVE, KEY_MIN, $urandom, 0);
		plan_request(CMD_UNUSED, 32'sd5, $urandom, 0);
		plan_request(CMD_ADD, KEY_MAX, KEY_MIN, 0);
		plan_request(CMD_ADD, KEY_MIN, KEY_MAX, 0);
		plan_request(CMD_ADD, 32'sd0, -32'sd1, 0);
		plan_request(CMD_ADD, -32'sd1, 32'sh5555_5555, 0);
		plan_request(CMD_ADD, 32'sd0, 32'sh1234_5678, 0);
		plan_request(CMD_SEARCH, KEY_MIN, $urandom, 0);
		plan_request(CMD_SEARCH, KEY_MAX, $urandom, 0);
		plan_request(CMD_SEARCH, 32'sd5, $urandom, 0);
		plan_request(CMD_REMOVE, -32'sd1, $urandom, 0);
		plan_request(CMD_REMOVE, 32'sd7, $urandom, 0);
		plan_request(CMD_REMOVE, KEY_MIN, $urandom, 0);
		plan_request(CMD_UNUSED, KEY_MAX, 32'shAAAA_AAAA, 0);

		// Switch to descending with pairs stored: the old chain keeps its order,
		// so a present key can be missed by search and added a second time.
		plan_marker(ENT_SETTLE, ORDER_ASCENDING);
		plan_marker(ENT_ORDER, ORDER_DESCENDING);
		plan_request(CMD_ADD, 32'sd100, $urandom, 0);
		plan_request(CMD_SEARCH, KEY_MAX, $urandom, 0);
		plan_request(CMD_ADD, KEY_MAX, 32'sd1, 0);
		plan_request(CMD_REMOVE, KEY_MAX, $urandom, 0);
		plan_request(CMD_SEARCH, 32'sd0, $urandom, 0);

		phase_no = 0;
		while (n_planned < PLANNED_REQUESTS) begin
			plan_marker(ENT_SETTLE, ORDER_ASCENDING);
			if (phase_no == 0)
				plan_marker(ENT_ORDER, ORDER_ASCENDING);
			else if (phase_no == 1)
				plan_marker(ENT_ORDER, ORDER_DESCENDING);
			else
				plan_marker(ENT_ORDER, logic'($urandom_range(0, 1)));
			calm = ($urandom_range(0, 3) == 0);
			if (phase_no == 1 || phase_no == 4) begin
				// Fill past capacity so that new keys are refused, then empty it.
				shuffle(idx);
				for (int i = 0; i < 72; i++)
					plan_request(CMD_ADD, pool[idx[i]], $urandom, calm);
				for (int i = 0; i < 8; i++)
					plan_request(CMD_SEARCH, pool[$urandom_range(0, 95)], $urandom, calm);
				shuffle(idx);
				for (int i = 0; i < 96; i++)
					plan_request(CMD_REMOVE, pool[idx[i]], $urandom, calm);
			end else begin
				// Mixed traffic, mostly on pooled keys so that hits are common.
				for (int i = 0; i < 40; i++) begin
					sel = $urandom_range(0, 99);
					if (sel < 40)
						op = CMD_ADD;
					else if (sel < 70)
						op = CMD_SEARCH;
					else if (sel < 95)
						op = CMD_REMOVE;
					else
						op = CMD_UNUSED;
					if ($urandom_range(0, 4) == 0)
						k = $urandom;
					else
						k = pool[$urandom_range(0, 95)];
					plan_request(op, k, $urandom, calm);
					if (i == 20 && $urandom_range(0, 1) == 0)
						plan_marker(ENT_SETTLE, ORDER_ASCENDING);
				end
			end
			phase_no++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the plan to run out and every result to arrive.
		do
			@(negedge clk);
		while (plan_q.size() != 0 || start || n_req != n_res);
		repeat (SLOTS + 10) @(negedge clk);
		if (expected_results.size() != 0)
			flag_mismatch("results never delivered", expected_results.size(), '0);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin : watchdog
		#1_200_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
